// ===== sv/brld_pkg.sv =====
package brld_pkg;

    // longest run that is expanded, and the width that holds 0..MAX_RUN
    localparam int MAX_RUN = 64;
    localparam int CNT_W   = $clog2(MAX_RUN + 1);

    // command queue between front and back
    localparam int QDEPTH = 2;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    // ascii digit range
    localparam logic [7:0] DIGIT_ZERO = 8'd48;
    localparam logic [7:0] DIGIT_NINE = 8'd57;

    // register indexes of the configuration port
    localparam logic [1:0] REG_ZERO_MARKER = 2'd0;
    localparam logic [1:0] REG_ONE_MARKER  = 2'd1;
    localparam logic [1:0] REG_ZERO_FILL   = 2'd2;
    localparam logic [1:0] REG_ONE_FILL    = 2'd3;

    // register reset values
    localparam logic [7:0] RST_ZERO_MARKER = 8'd45;
    localparam logic [7:0] RST_ONE_MARKER  = 8'd43;
    localparam logic [7:0] RST_ZERO_FILL   = 8'd48;
    localparam logic [7:0] RST_ONE_FILL    = 8'd49;

    typedef enum logic [1:0] {
        MODE_IDLE = 2'd0,
        MODE_ZERO = 2'd1,
        MODE_ONE  = 2'd2
    } run_mode_t;

    typedef struct packed {
        logic [7:0] zero_marker;
        logic [7:0] one_marker;
        logic [7:0] zero_fill;
        logic [7:0] one_fill;
    } cfg_t;

    // one queued command: emit data count times, last beat flagged
    typedef struct packed {
        logic [7:0]       data;
        logic [CNT_W-1:0] count;
        logic             clipped;
    } cmd_t;

endpackage

// ===== sv/brld_front.sv =====
module brld_front (
    input  logic          clk,
    input  logic          rst_n,
    input  brld_pkg::cfg_t cfg,
    input  logic          accept,
    input  logic [7:0]    in_byte,
    output logic          push,
    output brld_pkg::cmd_t push_cmd
);
    import brld_pkg::*;

    run_mode_t        mode_reg, mode_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             ended_reg, ended_next;
    logic             sat_reg, sat_next;

    logic       is_digit;
    logic [7:0] marker;
    logic [7:0] fill;
    logic [3:0] digit_val;
    logic [9:0] prod;

    // byte classification
    always_comb
    begin
        is_digit  = (in_byte inside {[DIGIT_ZERO:DIGIT_NINE]});
        digit_val = 4'(in_byte - DIGIT_ZERO);
        prod      = 10'({count_reg, 3'b000}) + 10'({count_reg, 1'b0}) + 10'(digit_val);
        marker    = (mode_reg == MODE_ONE) ? cfg.one_marker : cfg.zero_marker;
        fill      = (mode_reg == MODE_ONE) ? cfg.one_fill : cfg.zero_fill;
    end

    // next run mode
    always_comb
    begin
        mode_next = mode_reg;
        if (accept)
        begin
            case (mode_reg)
                MODE_ZERO, MODE_ONE:
                begin
                    if (in_byte == marker)
                        mode_next = MODE_IDLE;
                end
                default:
                begin
                    if (in_byte == cfg.zero_marker)
                        mode_next = MODE_ZERO;
                    else if (in_byte == cfg.one_marker)
                        mode_next = MODE_ONE;
                    else
                        mode_next = MODE_IDLE;
                end
            endcase
        end
    end

    // run length tracking and queue commands
    always_comb
    begin
        count_next = count_reg;
        ended_next = ended_reg;
        sat_next   = sat_reg;
        push       = 1'b0;
        push_cmd   = '{data: in_byte, count: CNT_W'(1), clipped: 1'b0};
        if (accept)
        begin
            case (mode_reg)
                MODE_ZERO, MODE_ONE:
                begin
                    if (in_byte == marker)
                    begin
                        push       = (count_reg != '0);
                        push_cmd   = '{data: fill, count: count_reg, clipped: sat_reg};
                        count_next = '0;
                        ended_next = 1'b0;
                        sat_next   = 1'b0;
                    end
                    else if (!ended_reg && is_digit)
                    begin
                        if (prod > 10'(MAX_RUN))
                        begin
                            count_next = CNT_W'(MAX_RUN);
                            sat_next   = 1'b1;
                        end
                        else
                        begin
                            count_next = CNT_W'(prod);
                        end
                    end
                    else
                    begin
                        ended_next = 1'b1;
                    end
                end
                default:
                begin
                    if (in_byte == cfg.zero_marker || in_byte == cfg.one_marker)
                    begin
                        count_next = '0;
                        ended_next = 1'b0;
                        sat_next   = 1'b0;
                    end
                    else
                    begin
                        push = 1'b1;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= MODE_IDLE;
            count_reg <= '0;
            ended_reg <= 1'b0;
            sat_reg   <= 1'b0;
        end
        else
        begin
            mode_reg  <= mode_next;
            count_reg <= count_next;
            ended_reg <= ended_next;
            sat_reg   <= sat_next;
        end
    end

endmodule

// ===== sv/brld_queue.sv =====
module brld_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  brld_pkg::cmd_t push_cmd,
    input  logic           pop,
    output brld_pkg::cmd_t head,
    output logic           empty,
    output logic           full
);
    import brld_pkg::*;

    cmd_t              slot_reg [QDEPTH];
    logic [QPTR_W-1:0] wptr_reg, wptr_next;
    logic [QPTR_W-1:0] rptr_reg, rptr_next;
    logic [QCNT_W-1:0] cnt_reg, cnt_next;

    // status and head
    always_comb
    begin
        empty = (cnt_reg == '0);
        full  = (cnt_reg == QCNT_W'(QDEPTH));
        head  = slot_reg[rptr_reg];
    end

    // pointer and fill count update
    always_comb
    begin
        wptr_next = wptr_reg;
        rptr_next = rptr_reg;
        cnt_next  = cnt_reg;
        if (push)
        begin
            wptr_next = (wptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : wptr_reg + 1'b1;
        end
        if (pop)
        begin
            rptr_next = (rptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : rptr_reg + 1'b1;
        end
        if (push && !pop)
            cnt_next = cnt_reg + 1'b1;
        else if (pop && !push)
            cnt_next = cnt_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            cnt_reg  <= '0;
        end
        else
        begin
            wptr_reg <= wptr_next;
            rptr_reg <= rptr_next;
            cnt_reg  <= cnt_next;
        end
    end

    // command storage
    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wptr_reg] <= push_cmd;
    end

`ifndef SYNTHESIS
    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        full |-> !push)
        else $error("command pushed into full queue");
    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        empty |-> !pop)
        else $error("command popped from empty queue");
    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= QCNT_W'(QDEPTH))
        else $error("queue fill count out of range");
`endif

endmodule

// ===== sv/brld_back.sv =====
module brld_back (
    input  logic           clk,
    input  logic           rst_n,
    input  brld_pkg::cmd_t head,
    input  logic           empty,
    output logic           pop,
    output logic           m_tvalid,
    input  logic           m_tready,
    output logic [7:0]     m_tdata,
    output logic           m_tlast,
    output logic           m_tuser
);
    import brld_pkg::*;

    logic             active_reg, active_next;
    logic [CNT_W-1:0] rem_reg, rem_next;
    logic [7:0]       data_reg;
    logic             clip_reg;
    logic             beat;
    logic             final_beat;

    // beat and command hand-over
    always_comb
    begin
        beat       = active_reg && m_tready;
        final_beat = beat && (rem_reg == CNT_W'(1));
        pop        = !empty && (!active_reg || final_beat);
        active_next = active_reg;
        rem_next    = rem_reg;
        if (pop)
        begin
            active_next = 1'b1;
            rem_next    = head.count;
        end
        else if (final_beat)
        begin
            active_next = 1'b0;
            rem_next    = '0;
        end
        else if (beat)
        begin
            rem_next = rem_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            rem_reg    <= '0;
        end
        else
        begin
            active_reg <= active_next;
            rem_reg    <= rem_next;
        end
    end

    // payload of the current command
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            data_reg <= head.data;
            clip_reg <= head.clipped;
        end
    end

    assign m_tvalid = active_reg;
    assign m_tdata  = data_reg;
    assign m_tlast  = (rem_reg == CNT_W'(1));
    assign m_tuser  = clip_reg;

`ifndef SYNTHESIS
    a_rem_range: assert property (@(posedge clk) disable iff (!rst_n)
        active_reg |-> (rem_reg != '0 && rem_reg <= CNT_W'(MAX_RUN)))
        else $error("remaining beat count out of range");
    a_idle_rem: assert property (@(posedge clk) disable iff (!rst_n)
        (beat && !final_beat) |=> active_reg)
        else $error("run dropped before its last beat");
`endif

endmodule

// ===== sv/binary_run_length_decoder_unit.sv =====
// binary run-length decoder
// slave stream s_*: one encoded byte per beat in s_tdata.
// master stream m_*: decoded bytes; m_tlast marks the final byte of an
// expanded run and every passed-through byte, m_tuser marks bytes of a run
// whose length was clipped to the maximum.
// cfg_we/cfg_index/cfg_wdata write the markers and fill bytes; write only
// while the block is idle.
// a passed-through byte or a closing marker is written as a command into
// the queue, which the back end then loads into its output registers.
// passed-through bytes flow at one per cycle while m_tready stays high. a
// closed run of n bytes is emitted as n fill bytes, one per cycle while
// m_tready stays high, counted down by the back end's beat counter; the
// two-entry command queue keeps the input open until it fills, after which
// s_tready drops until the run drains. opening markers, digits and empty
// runs produce no beat. when the receiver stalls, the current beat holds
// and input continues until the queue is full.
// reset: registers return to '-', '+', '0', '1', the decoder leaves any run
// and queued commands are discarded.
module binary_run_length_decoder_unit (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_we,
    input  logic [1:0] cfg_index,
    input  logic [7:0] cfg_wdata,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] in_byte
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [7:0] out_byte
    output logic       m_tlast,
    output logic       m_tuser    // [0] clipped
);
    import brld_pkg::*;

    cfg_t cfg_reg;
    logic push;
    cmd_t push_cmd;
    logic pop;
    cmd_t head;
    logic empty;
    logic full;
    logic accept;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.zero_marker <= RST_ZERO_MARKER;
            cfg_reg.one_marker  <= RST_ONE_MARKER;
            cfg_reg.zero_fill   <= RST_ZERO_FILL;
            cfg_reg.one_fill    <= RST_ONE_FILL;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_ZERO_MARKER: cfg_reg.zero_marker <= cfg_wdata;
                REG_ONE_MARKER:  cfg_reg.one_marker  <= cfg_wdata;
                REG_ZERO_FILL:   cfg_reg.zero_fill   <= cfg_wdata;
                REG_ONE_FILL:    cfg_reg.one_fill    <= cfg_wdata;
                default:         cfg_reg <= cfg_reg;
            endcase
        end
    end

    // input beat accepted whenever the queue has room
    assign s_tready = !full;
    assign accept   = s_tvalid && s_tready;

    brld_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg_reg),
        .accept   (accept),
        .in_byte  (s_tdata),
        .push     (push),
        .push_cmd (push_cmd)
    );

    brld_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .head     (head),
        .empty    (empty),
        .full     (full)
    );

    brld_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .head     (head),
        .empty    (empty),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

endmodule

// ===== verif/binary_run_length_decoder_unit_tb.sv =====
`timescale 1ns / 100ps

module binary_run_length_decoder_unit_tb;

    import brld_pkg::*;

    localparam int CYCLE_LIMIT   = 500000;
    localparam int SETTLE_CYCLES = 8;
    localparam int IDLE_PCT      = 38;

    // one decoded output beat
    typedef struct packed {
        logic [7:0] data;
        logic       last;
        logic       clip;
    } out_beat_t;

    logic       clk;
    logic       rst_n;
    logic       cfg_we;
    logic [1:0] cfg_index;
    logic [7:0] cfg_wdata;
    logic       s_tvalid;
    logic       s_tready;
    logic [7:0] s_tdata;
    logic       m_tvalid;
    logic       m_tready;
    logic [7:0] m_tdata;
    logic       m_tlast;
    logic       m_tuser;

    // decoder prediction state
    logic [7:0] zero_mark;
    logic [7:0] one_mark;
    logic [7:0] zero_fill_byte;
    logic [7:0] one_fill_byte;
    run_mode_t  cur_mode;
    logic [6:0] run_len;
    logic       digits_done;
    logic       len_sat;

    out_beat_t  decoded_fifo[$];
    int         mismatch_count;
    int         cycle_count;
    int         bytes_sent;
    logic       idle_en;

    binary_run_length_decoder_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser)
    );

    // 10 ns clock
    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // run watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    // receiver back-pressure
    always @(negedge clk)
    begin
        m_tready <= !idle_en || ($urandom_range(99) >= IDLE_PCT);
    end

    // compare each output beat with the oldest predicted one
    always @(posedge clk)
    begin : check_beats
        out_beat_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (decoded_fifo.size() == 0)
            begin
                $display("%0t unexpected beat: data %h last %b user %b",
                         $time, m_tdata, m_tlast, m_tuser);
                mismatch_count++;
            end
            else
            begin
                want = decoded_fifo.pop_front();
                if (want.data !== m_tdata || want.last !== m_tlast || want.clip !== m_tuser)
                begin
                    $display("%0t mismatch: expected data %h last %b user %b, got data %h last %b user %b",
                             $time, want.data, want.last, want.clip, m_tdata, m_tlast, m_tuser);
                    mismatch_count++;
                end
            end
        end
    end

    // advance the decoder prediction by one accepted byte
    function automatic void decode_byte(input logic [7:0] b);
        logic [7:0] mark;
        logic [7:0] fill;
        int         n;
        int         nxt;
        if (cur_mode != MODE_ZERO && cur_mode != MODE_ONE)
        begin
            if (b == zero_mark || b == one_mark)
            begin
                cur_mode    = (b == zero_mark) ? MODE_ZERO : MODE_ONE;
                run_len     = '0;
                digits_done = 1'b0;
                len_sat     = 1'b0;
            end
            else
            begin
                cur_mode = MODE_IDLE;
                decoded_fifo.push_back('{data: b, last: 1'b1, clip: 1'b0});
            end
        end
        else
        begin
            mark = (cur_mode == MODE_ZERO) ? zero_mark : one_mark;
            fill = (cur_mode == MODE_ZERO) ? zero_fill_byte : one_fill_byte;
            if (b == mark)
            begin
                // closing marker expands the run
                n = (int'(run_len) > MAX_RUN) ? MAX_RUN : int'(run_len);
                for (int k = 0; k < n; k++)
                    decoded_fifo.push_back('{data: fill, last: (k == n - 1), clip: len_sat});
                cur_mode    = MODE_IDLE;
                run_len     = '0;
                digits_done = 1'b0;
                len_sat     = 1'b0;
            end
            else if (!digits_done && b >= DIGIT_ZERO && b <= DIGIT_NINE)
            begin
                nxt = int'(run_len) * 10 + int'(b) - int'(DIGIT_ZERO);
                if (nxt > MAX_RUN)
                begin
                    run_len = 7'(MAX_RUN);
                    len_sat = 1'b1;
                end
                else
                begin
                    run_len = 7'(nxt);
                end
            end
            else
            begin
                digits_done = 1'b1;
            end
        end
    endfunction

    // drive one byte with random idle cycles, predict once accepted
    task automatic send_byte(input logic [7:0] b);
        @(negedge clk);
        while (idle_en && $urandom_range(99) < IDLE_PCT)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        do
            @(posedge clk);
        while (!s_tready);
        decode_byte(b);
        bytes_sent++;
    endtask

    // stop sending and wait until every predicted beat came out
    task automatic drain_outputs;
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (decoded_fifo.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // leave any open run so register writes happen outside a run
    task automatic close_run;
        if (cur_mode == MODE_ZERO)
            send_byte(zero_mark);
        else if (cur_mode == MODE_ONE)
            send_byte(one_mark);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [7:0] val);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(negedge clk);
        cfg_we    <= 1'b0;
        case (idx)
            REG_ZERO_MARKER: zero_mark      = val;
            REG_ONE_MARKER:  one_mark       = val;
            REG_ZERO_FILL:   zero_fill_byte = val;
            REG_ONE_FILL:    one_fill_byte  = val;
            default: ;
        endcase
    endtask

    task automatic write_all_regs(input logic [7:0] zm, input logic [7:0] om,
                                  input logic [7:0] zf, input logic [7:0] of);
        write_reg(REG_ZERO_MARKER, zm);
        write_reg(REG_ONE_MARKER, om);
        write_reg(REG_ZERO_FILL, zf);
        write_reg(REG_ONE_FILL, of);
    endtask

    // mostly well-formed runs with random lengths, plus passthrough and noise
    task automatic random_traffic(input int n);
        int         target;
        int         nd;
        logic [7:0] mk;
        target = bytes_sent + n;
        while (bytes_sent < target)
        begin
            if ($urandom_range(99) < 55)
            begin
                mk = $urandom_range(1) ? zero_mark : one_mark;
                send_byte(mk);
                nd = ($urandom_range(9) == 0) ? 3 : $urandom_range(2);
                for (int k = 0; k < nd; k++)
                    send_byte(DIGIT_ZERO + 8'($urandom_range(9)));
                if ($urandom_range(99) < 15)
                    send_byte(8'($urandom_range(255)));
                if ($urandom_range(99) < 90)
                    send_byte(mk);
            end
            else
            begin
                send_byte(8'($urandom_range(255)));
            end
        end
        close_run();
    endtask

    // plain bytes outside a run, including digits
    task automatic test_passthrough;
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(DIGIT_ZERO + 8'd7);
    endtask

    // ordinary zero and one runs, empty runs, and runs without digits
    task automatic test_runs;
        send_byte(zero_mark);
        send_byte(DIGIT_ZERO + 8'd5);
        send_byte(zero_mark);
        send_byte(one_mark);
        send_byte(DIGIT_ZERO + 8'd1);
        send_byte(DIGIT_ZERO + 8'd2);
        send_byte(one_mark);
        send_byte(zero_mark);
        send_byte(zero_mark);
        send_byte(one_mark);
        send_byte(8'h78);
        send_byte(one_mark);
    endtask

    // whitespace ends the number; a later digit and the other marker do not extend it
    task automatic test_number_end;
        send_byte(one_mark);
        send_byte(DIGIT_ZERO + 8'd3);
        send_byte(8'h20);
        send_byte(DIGIT_ZERO + 8'd5);
        send_byte(zero_mark);
        send_byte(one_mark);
    endtask

    // lengths above and exactly at the maximum
    task automatic test_saturation;
        send_byte(zero_mark);
        send_byte(DIGIT_ZERO + 8'd9);
        send_byte(DIGIT_ZERO + 8'd9);
        send_byte(zero_mark);
        send_byte(one_mark);
        send_byte(DIGIT_ZERO + 8'd6);
        send_byte(DIGIT_ZERO + 8'd4);
        send_byte(one_mark);
        drain_outputs();
    endtask

    // random traffic on the reset settings, with a full drain in the middle
    task automatic test_random_default;
        random_traffic(50);
        drain_outputs();
        random_traffic(50);
        drain_outputs();
    endtask

    // equal markers, a digit as marker, random and extreme register values
    task automatic test_register_settings;
        write_all_regs(8'h00, 8'h00, 8'hFF, 8'h00);
        random_traffic(50);
        drain_outputs();
        write_all_regs(DIGIT_ZERO + 8'd7, 8'hFF, 8'h00, 8'hFF);
        random_traffic(50);
        drain_outputs();
        write_all_regs(8'($urandom_range(255)), 8'($urandom_range(255)),
                       8'($urandom_range(255)), 8'($urandom_range(255)));
        random_traffic(50);
        drain_outputs();
    endtask

    // back on reset values with both sides always ready
    task automatic test_no_idle;
        write_all_regs(RST_ZERO_MARKER, RST_ONE_MARKER, RST_ZERO_FILL, RST_ONE_FILL);
        idle_en = 1'b0;
        random_traffic(60);
        drain_outputs();
        idle_en = 1'b1;
    endtask

    initial
    begin
        rst_n          = 1'b0;
        cfg_we         = 1'b0;
        cfg_index      = REG_ZERO_MARKER;
        cfg_wdata      = 8'h00;
        s_tvalid       = 1'b0;
        s_tdata        = 8'h00;
        m_tready       = 1'b0;
        idle_en        = 1'b1;
        mismatch_count = 0;
        cycle_count    = 0;
        bytes_sent     = 0;
        zero_mark      = RST_ZERO_MARKER;
        one_mark       = RST_ONE_MARKER;
        zero_fill_byte = RST_ZERO_FILL;
        one_fill_byte  = RST_ONE_FILL;
        cur_mode       = MODE_IDLE;
        run_len        = '0;
        digits_done    = 1'b0;
        len_sat        = 1'b0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_passthrough();
        test_runs();
        test_number_end();
        test_saturation();
        test_random_default();
        test_register_settings();
        test_no_idle();

        if (mismatch_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

// ===== filelist.f =====
sv/brld_pkg.sv
sv/brld_front.sv
sv/brld_queue.sv
sv/brld_back.sv
sv/binary_run_length_decoder_unit.sv
verif/binary_run_length_decoder_unit_tb.sv
